[rtl/output_journal_upsert_table_defines.svh]
// assertion macros for the output journal upsert table
`ifndef OUTPUT_JOURNAL_UPSERT_TABLE_DEFINES_SVH
`define OUTPUT_JOURNAL_UPSERT_TABLE_DEFINES_SVH

// implication checked on every clock edge outside reset
`define OJU_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// implication whose consequent is checked in the next cycle
`define OJU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

[rtl/oju_pkg.sv]
`timescale 1ns / 1ps
// ------------------------------------------------------------------------
// oju_pkg
// types and constants shared by the journal table cells and top level
// ------------------------------------------------------------------------
package oju_pkg;
	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_INVALID = 2'd1;
	localparam logic [1:0] ST_FULL    = 2'd2;
	localparam logic [1:0] TIER_DEVICE = 2'd0;
	localparam logic [1:0] TIER_HOST   = 2'd1;
	localparam logic [31:0] FRAME_BAD  = 32'hFFFF_FFFF;

	localparam logic [2:0] CFG_STARTED   = 3'd0;
	localparam logic [2:0] CFG_SCAN      = 3'd1;
	localparam logic [2:0] CFG_GEN       = 3'd2;
	localparam logic [2:0] CFG_TOKEN     = 3'd3;
	localparam logic [2:0] CFG_JOURNAL   = 3'd4;

	typedef struct packed {
		logic [31:0] frame;
		logic [63:0] key;
		logic [1:0]  tier;
		logic [63:0] generation;
	} row_t;

	// per-cell match flags reported to the control
	typedef struct packed {
		logic bad;
		logic fmatch;
		logic kmatch;
	} cell_flags_t;

	// write command decoded for each cell of the row
	typedef struct packed {
		logic wr_new;
		logic wr_move;
	} cell_cmd_t;
endpackage

[rtl/oju_if.sv]
`timescale 1ns / 1ps
// ------------------------------------------------------------------------
// oju_in_if / oju_out_if / oju_cfg_if
// valid-ready channels of the journal table
// ------------------------------------------------------------------------
interface oju_in_if;
	logic        valid;
	logic        ready;
	logic [31:0] frame;
	logic [63:0] cache_key;
	logic [1:0]  tier;
	logic        owner_ok;
	logic        tag_ok;
	modport source (output valid, frame, cache_key, tier, owner_ok, tag_ok, input ready);
	modport sink (input valid, frame, cache_key, tier, owner_ok, tag_ok, output ready);
endinterface

interface oju_out_if;
	logic       valid;
	logic       ready;
	logic [1:0] status;
	logic [4:0] row_count;
	logic       wrote_any;
	modport source (output valid, status, row_count, wrote_any, input ready);
	modport sink (input valid, status, row_count, wrote_any, output ready);
endinterface

interface oju_cfg_if;
	logic        valid;
	logic        ready;
	logic [2:0]  index;
	logic [63:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

[rtl/output_journal_upsert_table.sv]
`timescale 1ns / 1ps
// ------------------------------------------------------------------------
// output_journal_upsert_table
// journal of output rows updated by one record request per transaction
// ------------------------------------------------------------------------
// Usage: requests enter on the in channel (frame, cache_key, tier, owner_ok,
// tag_ok); one result (status, row_count, wrote_any) leaves on the out
// channel for each. Registers are to be written over the cfg channel only
// while idle (the block does not enforce it): index 0 started, 1 scan_mode,
// 2 generation, 3 token_valid, 4 journal_present; other indexes are ignored.
// Flow: the request is registered, all rows compare in parallel in the
// next cycle where the decision and the row write happen, and the result
// sits in an output register. The block holds one request at a time and
// takes the next one once the result register is free or being emptied.
// Reset clears the row count, the active flag and the registers; row
// contents are undefined and are never read before they are written.
// A stalled receiver keeps the result held and the input not ready.
// ------------------------------------------------------------------------
`include "output_journal_upsert_table_defines.svh"
module output_journal_upsert_table
	import oju_pkg::*;
#(
	parameter int ROWS = 16
)(
	input  logic      clk,
	input  logic      arst_n,
	oju_in_if.sink    in_ch,
	oju_out_if.source out_ch,
	oju_cfg_if.sink   cfg
);
	localparam int IW = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam int CW = $clog2(ROWS + 1);

	logic        started_q, scan_q, token_q, journal_q;
	logic [63:0] gen_q;
	logic [CW-1:0] used_q;
	logic        active_q;

	logic        busy_q;
	logic [31:0] frame_s1;
	logic [63:0] key_s1;
	logic [1:0]  tier_s1;
	logic        owner_s1, tag_s1;

	logic        ovalid_q;
	logic [1:0]  status_q;
	logic [4:0]  count_q;
	logic        oactive_q;

	row_t        rows [ROWS];
	cell_flags_t flags [ROWS];
	cell_cmd_t   cmds [ROWS];
	row_t        new_row, last_row;

	assign cfg.ready = 1'b1;
	assign in_ch.ready = !busy_q && (!ovalid_q || out_ch.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			started_q <= 1'b0;
			scan_q    <= 1'b0;
			token_q   <= 1'b0;
			journal_q <= 1'b0;
			gen_q     <= '0;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				CFG_STARTED: started_q <= cfg.data[0];
				CFG_SCAN:    scan_q    <= cfg.data[0];
				CFG_GEN:     gen_q     <= cfg.data;
				CFG_TOKEN:   token_q   <= cfg.data[0];
				CFG_JOURNAL: journal_q <= cfg.data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready) begin
			frame_s1 <= in_ch.frame;
			key_s1   <= in_ch.cache_key;
			tier_s1  <= in_ch.tier;
			owner_s1 <= in_ch.owner_ok;
			tag_s1   <= in_ch.tag_ok;
		end
	end

	assign new_row = '{frame: frame_s1, key: key_s1, tier: tier_s1, generation: gen_q};

	// match scan: independent per-row flags reduced to match and double-match flags and indexes
	logic          any_bad, fm, km, fm2, km2;
	logic [IW-1:0] fi, ki, last;
	row_t          frow, krow;

	always_comb begin
		any_bad = 1'b0;
		fm = 1'b0; km = 1'b0; fm2 = 1'b0; km2 = 1'b0;
		fi = '0; ki = '0;
		for (int i = 0; i < ROWS; i++) begin
			any_bad = any_bad | flags[i].bad;
			if (flags[i].fmatch) begin
				fm2 = fm2 | fm;
				fm = 1'b1;
				fi = IW'(i);
			end
			if (flags[i].kmatch) begin
				km2 = km2 | km;
				km = 1'b1;
				ki = IW'(i);
			end
		end
		last = IW'(used_q - CW'(1));
		frow = rows[fi];
		krow = rows[ki];
		last_row = rows[last];
	end

	// decision
	logic [1:0]    st;
	logic          do_new, do_move, inc, dec;
	logic [IW-1:0] new_idx, move_idx;

	always_comb begin
		st = ST_OK;
		do_new = 1'b0; do_move = 1'b0; inc = 1'b0; dec = 1'b0;
		new_idx = '0; move_idx = '0;
		if (!started_q || !scan_q) begin
			st = ST_OK;
		end else if (frame_s1 == FRAME_BAD || gen_q == 64'd0 || !token_q ||
				!owner_s1 || !tag_s1 || !journal_q || any_bad || fm2 || km2) begin
			st = ST_INVALID;
		end else if (!fm && !km) begin
			if (used_q >= CW'(ROWS)) begin
				st = ST_FULL;
			end else begin
				do_new = 1'b1; inc = 1'b1;
				new_idx = IW'(used_q);
			end
		end else if (fm && (!km || fi == ki)) begin
			if (frow.generation != gen_q) begin
				st = ST_INVALID;
			end else begin
				do_new = 1'b1; new_idx = fi;
			end
		end else if (!fm) begin
			if (krow.generation != gen_q) begin
				st = ST_INVALID;
			end else if (krow.tier == TIER_HOST && tier_s1 == TIER_DEVICE) begin
				st = ST_OK;
			end else if (krow.tier != TIER_DEVICE || tier_s1 != TIER_HOST) begin
				st = ST_INVALID;
			end else begin
				do_new = 1'b1; new_idx = ki;
			end
		end else if (frow.generation != gen_q || krow.generation != gen_q ||
				frow.tier != TIER_HOST || krow.tier != TIER_DEVICE ||
				tier_s1 != TIER_HOST) begin
			st = ST_INVALID;
		end else begin
			do_new = 1'b1; dec = 1'b1;
			if (fi == last) begin
				new_idx = ki;
			end else begin
				new_idx = fi;
				do_move = (ki != last);
				move_idx = ki;
			end
		end
	end

	logic fire;
	assign fire = busy_q;

	for (genvar g = 0; g < ROWS; g++) begin : g_cell
		assign cmds[g].wr_new  = fire && do_new && (new_idx == IW'(g));
		assign cmds[g].wr_move = fire && do_move && (move_idx == IW'(g));
		oju_cell u_cell (
			.clk      (clk),
			.used     (CW'(g) < used_q),
			.frame    (frame_s1),
			.key      (key_s1),
			.new_row  (new_row),
			.move_row (last_row),
			.cmd      (cmds[g]),
			.row      (rows[g]),
			.flags    (flags[g])
		);
	end

	logic [CW-1:0] used_next;
	assign used_next = inc ? used_q + CW'(1) : (dec ? used_q - CW'(1) : used_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q    <= 1'b0;
			used_q    <= '0;
			active_q  <= 1'b0;
			ovalid_q  <= 1'b0;
		end else begin
			if (ovalid_q && out_ch.ready) begin
				ovalid_q <= 1'b0;
			end
			if (in_ch.valid && in_ch.ready) begin
				busy_q <= 1'b1;
			end else if (fire) begin
				busy_q   <= 1'b0;
				ovalid_q <= 1'b1;
				used_q   <= used_next;
				active_q <= active_q | do_new;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			status_q  <= st;
			count_q   <= 5'(used_next);
			oactive_q <= active_q | do_new;
		end
	end

	assign out_ch.valid     = ovalid_q;
	assign out_ch.status    = status_q;
	assign out_ch.row_count = count_q;
	assign out_ch.wrote_any = oactive_q;

	`OJU_ASSERT_IMP(a_count_range, clk, arst_n, 1'b1, used_q <= CW'(ROWS))
	`OJU_ASSERT_IMP(a_no_accept_busy, clk, arst_n, busy_q, !in_ch.ready)
	`OJU_ASSERT_NEXT(a_fire_gives_result, clk, arst_n, fire, ovalid_q && !busy_q)
	`OJU_ASSERT_IMP(a_full_no_write, clk, arst_n, fire && st == ST_FULL, !do_new)
endmodule

[rtl/oju_cell.sv]
`timescale 1ns / 1ps
// ------------------------------------------------------------------------
// oju_cell
// one journal row: compares against the request, loads a new row or takes
// the row handed from the last slot
// ------------------------------------------------------------------------
module oju_cell
	import oju_pkg::*;
(
	input  logic        clk,
	input  logic        used,
	input  logic [31:0] frame,
	input  logic [63:0] key,
	input  row_t        new_row,
	input  row_t        move_row,
	input  cell_cmd_t   cmd,
	output row_t        row,
	output cell_flags_t flags
);
	row_t row_q;

	always_ff @(posedge clk) begin
		if (cmd.wr_new) begin
			row_q <= new_row;
		end else if (cmd.wr_move) begin
			row_q <= move_row;
		end
	end

	assign row = row_q;

	always_comb begin
		flags.bad    = used && ((row_q.generation == 64'd0) ||
			(row_q.tier != TIER_DEVICE && row_q.tier != TIER_HOST));
		flags.fmatch = used && (row_q.frame == frame);
		flags.kmatch = used && (row_q.key == key);
	end
endmodule

[tb/sv/journal_checker.sv]
`timescale 1ns / 1ps
// ------------------------------------------------------------------------
// journal_checker
// watches the request, result and register channels of the journal table,
// keeps its own copy of the rows and registers, predicts the result of
// every accepted request and compares it field by field
// ------------------------------------------------------------------------
module journal_checker
	import oju_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	oju_in_if    in_ch,
	oju_out_if   out_ch,
	oju_cfg_if   cfg,
	output int   errors,
	output int   pending,
	output int   n_checked,
	output int   n_full,
	output int   n_invalid
);
	localparam int NROWS = 16;

	typedef struct packed {
		logic [1:0] status;
		logic [4:0] row_count;
		logic       wrote_any;
	} outcome_t;

	logic [31:0] jr_frame [NROWS];
	logic [63:0] jr_key [NROWS];
	logic [1:0]  jr_tier [NROWS];
	logic [63:0] jr_gen [NROWS];
	int unsigned used;
	logic        active;

	logic        r_started, r_scan, r_token, r_journal;
	logic [63:0] r_gen;

	outcome_t outcomes [$];

	task automatic write_row(input int unsigned slot, input logic [31:0] f,
			input logic [63:0] k, input logic [1:0] t);
		if (slot < NROWS) begin
			jr_frame[slot] = f;
			jr_key[slot] = k;
			jr_tier[slot] = t;
			jr_gen[slot] = r_gen;
			active = 1'b1;
		end
	endtask

	task automatic upsert(input logic [31:0] f, input logic [63:0] k, input logic [1:0] t,
			input logic own, input logic tag, output logic [1:0] st);
		int unsigned fi, ki, last;
		logic fm, km;
		fi = 0;
		ki = 0;
		fm = 1'b0;
		km = 1'b0;
		st = ST_INVALID;
		if (!r_started || !r_scan) begin
			st = ST_OK;
			return;
		end
		if (f == FRAME_BAD || r_gen == 64'd0 || !r_token) return;
		if (!own || !tag || !r_journal) return;
		if (used > NROWS) return;
		for (int i = 0; i < used; i++) begin
			if (jr_gen[i] == 64'd0 || (jr_tier[i] != TIER_DEVICE && jr_tier[i] != TIER_HOST))
				return;
			if (jr_frame[i] == f) begin
				if (fm) return;
				fm = 1'b1;
				fi = i;
			end
			if (jr_key[i] == k) begin
				if (km) return;
				km = 1'b1;
				ki = i;
			end
		end
		if (!fm && !km) begin
			if (used >= NROWS) begin
				st = ST_FULL;
				return;
			end
			write_row(used, f, k, t);
			used++;
			st = ST_OK;
			return;
		end
		if (fm && (!km || fi == ki)) begin
			if (jr_gen[fi] != r_gen) return;
			write_row(fi, f, k, t);
			st = ST_OK;
			return;
		end
		if (!fm) begin
			if (jr_gen[ki] != r_gen) return;
			if (jr_tier[ki] == TIER_HOST && t == TIER_DEVICE) begin
				st = ST_OK;
				return;
			end
			if (jr_tier[ki] != TIER_DEVICE || t != TIER_HOST) return;
			write_row(ki, f, k, t);
			st = ST_OK;
			return;
		end
		// frame in one row, key in another: fold them into one row
		if (jr_gen[fi] != r_gen || jr_gen[ki] != r_gen || jr_tier[fi] != TIER_HOST ||
				jr_tier[ki] != TIER_DEVICE || t != TIER_HOST)
			return;
		last = used - 1;
		if (fi == last) begin
			write_row(ki, f, k, t);
		end else begin
			write_row(fi, f, k, t);
			if (ki != last) begin
				jr_frame[ki] = jr_frame[last];
				jr_key[ki] = jr_key[last];
				jr_tier[ki] = jr_tier[last];
				jr_gen[ki] = jr_gen[last];
			end
		end
		used--;
		st = ST_OK;
	endtask

	always @(posedge clk or negedge arst_n) begin
		outcome_t want;
		logic [1:0] st;
		if (!arst_n) begin
			used = 0;
			active = 1'b0;
			r_started = 1'b0;
			r_scan = 1'b0;
			r_gen = 64'd0;
			r_token = 1'b0;
			r_journal = 1'b0;
			outcomes.delete();
			errors = 0;
			pending = 0;
			n_checked = 0;
			n_full = 0;
			n_invalid = 0;
		end else begin
			if (out_ch.valid && out_ch.ready) begin
				if (outcomes.size() == 0) begin
					$error("result transaction with nothing expected");
					errors++;
				end else begin
					want = outcomes.pop_front();
					n_checked++;
					if (out_ch.status !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, out_ch.status);
						errors++;
					end
					if (out_ch.row_count !== want.row_count) begin
						$error("row_count: expected %0d, got %0d", want.row_count,
							out_ch.row_count);
						errors++;
					end
					if (out_ch.wrote_any !== want.wrote_any) begin
						$error("wrote_any: expected %0d, got %0d", want.wrote_any,
							out_ch.wrote_any);
						errors++;
					end
				end
			end
			if (in_ch.valid && in_ch.ready) begin
				upsert(in_ch.frame, in_ch.cache_key, in_ch.tier, in_ch.owner_ok,
					in_ch.tag_ok, st);
				if (st == ST_FULL) n_full++;
				if (st == ST_INVALID) n_invalid++;
				want.status = st;
				want.row_count = used[4:0];
				want.wrote_any = active;
				outcomes.push_back(want);
			end
			if (cfg.valid && cfg.ready) begin
				case (cfg.index)
					CFG_STARTED: r_started = cfg.data[0];
					CFG_SCAN:    r_scan = cfg.data[0];
					CFG_GEN:     r_gen = cfg.data;
					CFG_TOKEN:   r_token = cfg.data[0];
					CFG_JOURNAL: r_journal = cfg.data[0];
					default: ;
				endcase
			end
			pending = outcomes.size();
		end
	end
endmodule

[tb/sv/tb_output_journal_upsert_table.sv]
`timescale 1ns / 1ps
// ------------------------------------------------------------------------
// tb_output_journal_upsert_table
// drives record requests and register writes into the journal table with
// random idling on both channels; a directed walk through the idle, reject,
// append, overwrite, key-only and merge cases is followed by random phases
// over small frame and key pools so that rows match often
// ------------------------------------------------------------------------
module tb_output_journal_upsert_table;
	import oju_pkg::*;

	logic clk;
	logic arst_n;
	int   errors, pending, n_checked, n_full, n_invalid;
	logic burst_mode;   // no idling on either side
	logic stall_req;
	logic stall_done;
	int   stall_left;

	logic [31:0] frame_pool [6];
	logic [63:0] key_pool [6];

	oju_in_if  in_ch ();
	oju_out_if out_ch ();
	oju_cfg_if cfg ();

	output_journal_upsert_table u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch),
		.cfg    (cfg)
	);

	journal_checker u_chk (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ch     (in_ch),
		.out_ch    (out_ch),
		.cfg       (cfg),
		.errors    (errors),
		.pending   (pending),
		.n_checked (n_checked),
		.n_full    (n_full),
		.n_invalid (n_invalid)
	);

	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	// receiver: random back-pressure, or one long hold when asked
	always @(negedge clk) begin
		if (!arst_n) begin
			out_ch.ready = 1'b0;
			stall_done = 1'b0;
			stall_left = 0;
		end else if (stall_req && !stall_done) begin
			if (stall_left == 0) stall_left = 80;
			out_ch.ready = 1'b0;
			stall_left--;
			if (stall_left == 0) stall_done = 1'b1;
		end else begin
			if (!stall_req) stall_done = 1'b0;
			out_ch.ready = burst_mode || ($urandom_range(99) >= 33);
		end
	end

	task automatic quiet_gap();
		int n;
		if (!burst_mode && $urandom_range(99) < 33) begin
			n = $urandom_range(1, 4);
			@(negedge clk);
			in_ch.valid = 1'b0;
			repeat (n - 1) @(negedge clk);
		end
	endtask

	task automatic rec(input logic [31:0] f, input logic [63:0] k, input logic [1:0] t,
			input logic own = 1'b1, input logic tag = 1'b1);
		quiet_gap();
		@(negedge clk);
		in_ch.valid = 1'b1;
		in_ch.frame = f;
		in_ch.cache_key = k;
		in_ch.tier = t;
		in_ch.owner_ok = own;
		in_ch.tag_ok = tag;
		do @(posedge clk); while (!in_ch.ready);
	endtask

	task automatic settle();
		@(negedge clk);
		in_ch.valid = 1'b0;
		wait (pending == 0);
		repeat (4) @(negedge clk);
	endtask

	task automatic reg_write(input logic [2:0] idx, input logic [63:0] val);
		@(negedge clk);
		cfg.valid = 1'b1;
		cfg.index = idx;
		cfg.data = val;
		do @(posedge clk); while (!cfg.ready);
		@(negedge clk);
		cfg.valid = 1'b0;
	endtask

	task automatic setup(input logic s, input logic sc, input logic [63:0] g,
			input logic tv, input logic jp);
		settle();
		reg_write(CFG_STARTED, {63'd0, s});
		reg_write(CFG_SCAN, {63'd0, sc});
		reg_write(CFG_GEN, g);
		reg_write(CFG_TOKEN, {63'd0, tv});
		reg_write(CFG_JOURNAL, {63'd0, jp});
	endtask

	function automatic logic [63:0] rand64();
		return {$urandom(), $urandom()};
	endfunction

	initial begin
		logic [63:0] gen;
		logic        wide;
		arst_n = 1'b0;
		burst_mode = 1'b0;
		stall_req = 1'b0;
		in_ch.valid = 1'b0;
		in_ch.frame = '0;
		in_ch.cache_key = '0;
		in_ch.tier = TIER_DEVICE;
		in_ch.owner_ok = 1'b0;
		in_ch.tag_ok = 1'b0;
		cfg.valid = 1'b0;
		cfg.index = '0;
		cfg.data = '0;
		repeat (2) @(negedge clk);
		arst_n = 1'b1;

		// not started, then not scanning
		setup(1'b0, 1'b1, 64'd5, 1'b1, 1'b1);
		rec(32'd1, 64'd1, TIER_HOST);
		setup(1'b1, 1'b0, 64'd5, 1'b1, 1'b1);
		rec(32'd1, 64'd1, TIER_HOST);
		setup(1'b1, 1'b1, 64'd5, 1'b1, 1'b1);
		rec(FRAME_BAD, 64'd1, TIER_HOST);
		rec(32'd1, 64'd1, TIER_HOST, 1'b0, 1'b1);
		rec(32'd1, 64'd1, TIER_HOST, 1'b1, 1'b0);
		setup(1'b1, 1'b1, 64'd5, 1'b0, 1'b1);
		rec(32'd1, 64'd1, TIER_HOST);
		setup(1'b1, 1'b1, 64'd5, 1'b1, 1'b0);
		rec(32'd1, 64'd1, TIER_HOST);
		setup(1'b1, 1'b1, 64'd0, 1'b1, 1'b1);
		rec(32'd1, 64'd1, TIER_HOST);
		setup(1'b1, 1'b1, 64'd5, 1'b1, 1'b1);
		rec(32'd1, 64'd1, TIER_HOST);        // append
		rec(32'd2, 64'd2, TIER_DEVICE);      // append
		rec(32'd1, 64'd9, TIER_HOST);        // frame match, overwrite
		rec(32'd3, 64'd2, TIER_HOST);        // key only, device row upgraded
		rec(32'd4, 64'd2, TIER_DEVICE);      // key only, host row kept
		rec(32'd4, 64'd2, TIER_HOST);        // key only, host on host rejected
		rec(32'd5, 64'd5, TIER_DEVICE);
		rec(32'd6, 64'd6, TIER_DEVICE);
		rec(32'd1, 64'd5, TIER_HOST);        // merge of two rows
		rec(32'd0, 64'd0, TIER_DEVICE);
		rec(32'hFFFF_FFFE, 64'hFFFF_FFFF_FFFF_FFFF, TIER_HOST);
		setup(1'b1, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b1);
		rec(32'd1, 64'd1, TIER_HOST);        // generation mismatch on frame match
		rec(32'd77, 64'd6, TIER_HOST);       // generation mismatch on key match

		// random phases
		for (int ph = 0; ph < 8; ph++) begin
			case (ph % 4)
				0: gen = 64'd1;
				1: gen = 64'hFFFF_FFFF_FFFF_FFFF;
				2: gen = rand64();
				default: gen = 64'd5;
			endcase
			setup(ph == 5 ? 1'b0 : 1'b1, 1'b1, gen, 1'b1, 1'b1);
			foreach (frame_pool[i]) frame_pool[i] = $urandom();
			foreach (key_pool[i]) key_pool[i] = rand64();
			wide = (ph >= 6);
			burst_mode = (ph == 3);
			stall_req = (ph == 1);
			for (int n = 0; n < 50; n++) begin
				if (ph == 2 && n == 25) settle();
				if (wide || $urandom_range(9) == 0)
					rec($urandom(), rand64(), 2'($urandom_range(1)),
						$urandom_range(19) != 0, $urandom_range(19) != 0);
				else
					rec(frame_pool[$urandom_range(5)], key_pool[$urandom_range(5)],
						2'($urandom_range(1)), $urandom_range(19) != 0,
						$urandom_range(19) != 0);
			end
			stall_req = 1'b0;
			burst_mode = 1'b0;
		end

		// a stored row of another tier spoils every later request
		setup(1'b1, 1'b1, 64'd9, 1'b1, 1'b1);
		rec(32'h1234_5678, 64'h0123_4567_89AB_CDEF, 2'd2);
		rec(32'h8765_4321, 64'hFEDC_BA98_7654_3210, 2'd3);
		rec(32'h1111_1111, 64'h2222_2222_2222_2222, TIER_HOST);

		settle();
		repeat (10) @(posedge clk);
		$display("checked %0d results, %0d rejected as invalid, %0d refused as full",
			n_checked, n_invalid, n_full);
		$display("covered idle, rejects, append, overwrite, key-only tiers, merge, long stall");
		if (errors == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

	initial begin
		#5ms;
		$display("timeout");
		$display("end of test: mismatches");
		$finish;
	end
endmodule
